// ===== rtl/kes_pkg.sv =====
package kes_pkg;

    localparam int MAX_ITERATIONS  = 25;
    localparam int ANGLE_FRAC_BITS = 27;
    localparam int CORDIC_STEPS    = 30;
    localparam int ITER_W          = $clog2(MAX_ITERATIONS + 1);
    localparam int STEP_W          = $clog2(CORDIC_STEPS);

    // CORDIC datapath width: the estimate scaled to Q30 plus two guard bits.
    localparam int ZW              = 34 + 30 - ANGLE_FRAC_BITS;

    // Quotient bits needed to tell whether a correction exceeds 2 rad.
    localparam int QW              = ANGLE_FRAC_BITS + 2;
    localparam int QSH_W           = $clog2(QW + 1);

    localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
    localparam logic [63:0] TWO_PI_Q30 = (TWO_PI_Q60 + (64'd1 << 29)) >> 30;
    localparam logic [63:0] PI_Q30     = (TWO_PI_Q60 + (64'd1 << 30)) >> 31;
    localparam logic [63:0] HALF_PI_Q30 = (TWO_PI_Q60 + (64'd1 << 31)) >> 32;
    localparam logic [63:0] PERIOD_RED =
        (TWO_PI_Q60 + (64'd1 << (31 - ANGLE_FRAC_BITS))) >> (32 - ANGLE_FRAC_BITS);
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [32:0] divisor;
    } kes_div_req_t;

    typedef struct packed {
        logic          done;
        logic          big;
        logic [QW-1:0] quotient;
    } kes_div_rsp_t;

    function automatic logic [31:0] atan_q30(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            0:       v = 32'd843314857;
            1:       v = 32'd497837829;
            2:       v = 32'd263043837;
            3:       v = 32'd133525159;
            4:       v = 32'd67021687;
            5:       v = 32'd33543516;
            6:       v = 32'd16775851;
            7:       v = 32'd8388437;
            8:       v = 32'd4194283;
            9:       v = 32'd2097149;
            default: v = 32'd1 << (STEP_W'(30) - i);
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/kes_div.sv =====
module kes_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  kes_pkg::kes_div_req_t req,
    output kes_pkg::kes_div_rsp_t rsp
);
    import kes_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic             big_reg;
    logic [63:0]      rem_reg;
    logic [32:0]      div_reg;
    logic [QSH_W-1:0] sh_reg;
    logic [QW-1:0]    quo_reg;
    logic [63:0]      trial;
    logic             ge;
    logic             finish;

    // The first trial tests the bit just above the quotient; passing it means
    // the quotient is too large to matter.
    assign trial  = {31'd0, div_reg} << sh_reg;
    assign ge     = rem_reg >= trial;
    assign finish = busy_reg && ((sh_reg == QSH_W'(QW) && ge) || sh_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= finish && !req.start;
            if (req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.dividend;
            div_reg <= req.divisor;
            sh_reg  <= QSH_W'(QW);
            quo_reg <= '0;
            big_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (sh_reg == QSH_W'(QW))
            begin
                big_reg <= ge;
            end
            else if (ge)
            begin
                rem_reg <= rem_reg - trial;
                quo_reg <= quo_reg | (QW'(1) << sh_reg);
            end
            if (sh_reg != '0)
            begin
                sh_reg <= sh_reg - 1'b1;
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.big      = big_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/kepler_eccentric_anomaly_solver_unit.sv =====
// Kepler equation solver: eccentric anomaly E from mean anomaly M and
// eccentricity e, both taken in one input transfer (M signed Q4.27, e Q0.32).
// Each input transfer yields exactly one output transfer carrying E (Q4.27,
// saturated).
// The block works on one item at a time; in_ready is high only while the
// sequencer is idle. Per item it reduces M modulo 2*pi with a compare and
// subtract loop, then runs up to 25 Newton iterations. Each iteration runs
// the angle range reduction, the folding into [-pi, pi] and then into the
// right half plane, a CORDIC rotation, the shared multiplier for e*sin and
// e*cos, the setup of the Newton step, its denominator and range check, and
// the restoring divider; an iteration whose correction is too large to
// divide skips the divider and takes the fixed-point update. The time from
// input transfer to a valid output depends on how fast the item converges.
// The result sits in an output register. A new item may be accepted while
// that result still waits; if the receiver stalls and the next result is
// ready too, the sequencer holds it until the output register is taken.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops
// any pending output transfer.
module kepler_eccentric_anomaly_solver_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] mean_anomaly,
    input  logic        [31:0] eccentricity,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] eccentric_anomaly
);
    import kes_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_RED    = 15'b000000000000010,
        S_RFIN   = 15'b000000000000100,
        S_ZLOAD  = 15'b000000000001000,
        S_ZRED   = 15'b000000000010000,
        S_FOLD1  = 15'b000000000100000,
        S_FOLD2  = 15'b000000001000000,
        S_CORDIC = 15'b000000010000000,
        S_MULS   = 15'b000000100000000,
        S_MULC   = 15'b000001000000000,
        S_PREP   = 15'b000010000000000,
        S_CHECK  = 15'b000100000000000,
        S_DIV    = 15'b001000000000000,
        S_UPD    = 15'b010000000000000,
        S_DONE   = 15'b100000000000000
    } state_t;

    localparam logic signed [ZW-1:0] TWO_PI_Z  = ZW'(TWO_PI_Q30);
    localparam logic signed [ZW-1:0] PI_Z      = ZW'(PI_Q30);
    localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(HALF_PI_Q30);
    localparam logic [QW-1:0]        TWO_RAD   = QW'(1) << (ANGLE_FRAC_BITS + 1);

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -34'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    state_t                  state_reg, state_next;
    logic                    mneg_reg;
    logic [59:0]             rem_reg;
    logic [31:0]             ecc_reg;
    logic signed [31:0]      m_reg;
    logic signed [31:0]      est_reg;
    logic                    zneg_reg;
    logic [ZW-1:0]           zmag_reg;
    logic signed [ZW-1:0]    x_reg, y_reg, z_reg;
    logic                    flip_reg;
    logic [STEP_W-1:0]       cnt_reg;
    logic [ITER_W-1:0]       iter_reg;
    logic signed [64:0]      prod_reg;
    logic signed [31:0]      esin_reg;
    logic signed [31:0]      step_reg;
    logic [32:0]             den_reg;
    logic                    fb_reg;
    logic                    nneg_reg;
    logic signed [31:0]      result_reg;
    logic                    out_valid_reg;

    kes_div_req_t            div_req;
    kes_div_rsp_t            div_rsp;

    logic                    accept;
    logic                    out_load;
    logic [31:0]             in_mag;
    logic [30:0]             red_round;
    logic signed [ZW-1:0]    z_scaled;
    logic signed [ZW-1:0]    z_signed;
    logic signed [ZW-1:0]    cx, cy;
    logic signed [31:0]      mul_b;
    logic signed [64:0]      esin_full;
    logic signed [64:0]      ecos_full;
    logic signed [35:0]      den_full;
    logic signed [33:0]      step_full;
    logic signed [32:0]      num;
    logic [32:0]             num_mag;
    logic                    fallback;
    logic [33:0]             q_ext;
    logic signed [33:0]      est_sum;
    logic                    last_iter;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign in_mag    = mean_anomaly[31] ? (32'd0 - mean_anomaly) : mean_anomaly;
    assign red_round = 31'((rem_reg + 60'd134217728) >> 28);
    assign z_scaled  = ZW'(est_reg) <<< (30 - ANGLE_FRAC_BITS);
    assign z_signed  = zneg_reg ? -$signed(zmag_reg) : $signed(zmag_reg);
    assign cx        = y_reg >>> cnt_reg;
    assign cy        = x_reg >>> cnt_reg;

    // Shared multiplier: e*sin in S_MULS, e*cos in S_MULC.
    assign mul_b     = (state_reg == S_MULS) ? y_reg[31:0]
                                             : (flip_reg ? -x_reg[31:0] : x_reg[31:0]);
    assign esin_full = (prod_reg + (65'sd1 <<< (61 - ANGLE_FRAC_BITS)))
                       >>> (62 - ANGLE_FRAC_BITS);
    assign ecos_full = (prod_reg + (65'sd1 <<< 29)) >>> 30;
    assign den_full  = (36'sd1 <<< 32) - ecos_full[35:0];
    assign step_full = {{2{m_reg[31]}}, m_reg} + {{2{esin_reg[31]}}, esin_reg};

    assign num       = {step_reg[31], step_reg} - {est_reg[31], est_reg};
    assign num_mag   = num[32] ? (33'd0 - num) : num;

    // A correction above 2 rad, or one too large to divide, takes the
    // fixed-point update instead of the Newton step.
    assign fallback  = fb_reg || div_rsp.big || (div_rsp.quotient > TWO_RAD);
    assign q_ext     = {{(34 - QW){1'b0}}, div_rsp.quotient};
    assign est_sum   = {{2{est_reg[31]}}, est_reg} + (nneg_reg ? -$signed(q_ext)
                                                               : $signed(q_ext));
    assign last_iter = (iter_reg == ITER_W'(MAX_ITERATIONS - 1));

    assign div_req.start    = (state_reg == S_CHECK) && !(num_mag[32] || num_mag[31]);
    assign div_req.dividend = {1'b0, num_mag[30:0], 32'd0} + {32'd0, den_reg[32:1]};
    assign div_req.divisor  = den_reg;

    kes_div u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept) state_next = S_RED;
            S_RED:    if (rem_reg < PERIOD_RED[59:0]) state_next = S_RFIN;
            S_RFIN:   state_next = S_ZLOAD;
            S_ZLOAD:  state_next = S_ZRED;
            S_ZRED:   if (zmag_reg < TWO_PI_Q30[ZW-1:0]) state_next = S_FOLD1;
            S_FOLD1:  state_next = S_FOLD2;
            S_FOLD2:  state_next = S_CORDIC;
            S_CORDIC: if (cnt_reg == STEP_W'(CORDIC_STEPS - 1)) state_next = S_MULS;
            S_MULS:   state_next = S_MULC;
            S_MULC:   state_next = S_PREP;
            S_PREP:   state_next = S_CHECK;
            S_CHECK:  state_next = div_req.start ? S_DIV : S_UPD;
            S_DIV:    if (div_rsp.done) state_next = S_UPD;
            S_UPD:
            begin
                if ((!fallback && div_rsp.quotient == '0) || last_iter)
                    state_next = S_DONE;
                else
                    state_next = S_ZLOAD;
            end
            S_DONE:   if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_load || (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                mneg_reg <= mean_anomaly[31];
                rem_reg  <= {in_mag, 28'd0};
                ecc_reg  <= eccentricity;
                est_reg  <= '0;
                iter_reg <= '0;
            end
            S_RED:
            begin
                if (rem_reg >= PERIOD_RED[59:0])
                    rem_reg <= rem_reg - PERIOD_RED[59:0];
            end
            S_RFIN:
            begin
                m_reg <= mneg_reg ? -$signed({1'b0, red_round}) : $signed({1'b0, red_round});
            end
            S_ZLOAD:
            begin
                zneg_reg <= est_reg[31];
                zmag_reg <= est_reg[31] ? -z_scaled : z_scaled;
            end
            S_ZRED:
            begin
                if (zmag_reg >= TWO_PI_Q30[ZW-1:0])
                    zmag_reg <= zmag_reg - TWO_PI_Q30[ZW-1:0];
            end
            S_FOLD1:
            begin
                if (z_signed > PI_Z)
                    z_reg <= z_signed - TWO_PI_Z;
                else if (z_signed < -PI_Z)
                    z_reg <= z_signed + TWO_PI_Z;
                else
                    z_reg <= z_signed;
            end
            S_FOLD2:
            begin
                // Fold into the right half plane and negate cosine later.
                if (z_reg > HALF_PI_Z)
                begin
                    z_reg    <= PI_Z - z_reg;
                    flip_reg <= 1'b1;
                end
                else if (z_reg < -HALF_PI_Z)
                begin
                    z_reg    <= -PI_Z - z_reg;
                    flip_reg <= 1'b1;
                end
                else
                begin
                    flip_reg <= 1'b0;
                end
                x_reg   <= ZW'(CORDIC_GAIN_Q30);
                y_reg   <= '0;
                cnt_reg <= '0;
            end
            S_CORDIC:
            begin
                if (!z_reg[ZW-1])
                begin
                    x_reg <= x_reg - cx;
                    y_reg <= y_reg + cy;
                    z_reg <= z_reg - $signed(ZW'(atan_q30(cnt_reg)));
                end
                else
                begin
                    x_reg <= x_reg + cx;
                    y_reg <= y_reg - cy;
                    z_reg <= z_reg + $signed(ZW'(atan_q30(cnt_reg)));
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            S_MULS:
            begin
                prod_reg <= $signed({1'b0, ecc_reg}) * mul_b;
            end
            S_MULC:
            begin
                prod_reg <= $signed({1'b0, ecc_reg}) * mul_b;
                esin_reg <= esin_full[31:0];
            end
            S_PREP:
            begin
                step_reg <= sat32(step_full);
                den_reg  <= (den_full < 36'sd1) ? 33'd1 : den_full[32:0];
            end
            S_CHECK:
            begin
                nneg_reg <= num[32];
                fb_reg   <= num_mag[32] || num_mag[31];
            end
            S_UPD:
            begin
                est_reg  <= fallback ? step_reg : sat32(est_sum);
                iter_reg <= iter_reg + 1'b1;
            end
            S_DONE:
            begin
                if (out_load)
                    result_reg <= est_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid         = out_valid_reg;
    assign eccentric_anomaly = result_reg;

endmodule

// ===== tb/kes_checker.sv =====
module kes_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [31:0] mean_anomaly,
    input  logic        [31:0] eccentricity,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] eccentric_anomaly,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import kes_pkg::*;

    longint atan_tab [CORDIC_STEPS];
    logic [31:0] anomaly_q [$];

    function automatic longint atan_series(input int i);
        longint unsigned acc;
        longint unsigned term;
        int ex;
        int k;
        if (i == 0)
            return longint'((TWO_PI_Q60 + (64'd1 << 32)) >> 33);
        acc = 0;
        k = 0;
        forever
        begin
            ex = i * (2 * k + 1);
            if (ex > 62)
                break;
            term = (64'd1 << (62 - ex)) / longint'(2 * k + 1);
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
            k++;
        end
        return longint'((acc + (64'd1 << 31)) >> 32);
    endfunction

    initial
    begin
        for (int i = 0; i < CORDIC_STEPS; i++)
            atan_tab[i] = atan_series(i);
    end

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Rotation-mode CORDIC on the estimate, folded to the right half plane.
    function automatic void rotate_estimate(input longint est, output longint sn,
                                            output longint cs);
        longint two_pi;
        longint pi_v;
        longint half_pi;
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit flip;
        two_pi  = longint'(TWO_PI_Q30);
        pi_v    = longint'(PI_Q30);
        half_pi = longint'(HALF_PI_Q30);
        z = est * (64'sd1 <<< (30 - ANGLE_FRAC_BITS));
        x = longint'(CORDIC_GAIN_Q30);
        y = 0;
        flip = 1'b0;
        z = z % two_pi;
        if (z > pi_v)
            z = z - two_pi;
        else if (z < -pi_v)
            z = z + two_pi;
        if (z > half_pi)
        begin
            z = pi_v - z;
            flip = 1'b1;
        end
        else if (z < -half_pi)
        begin
            z = -pi_v - z;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_tab[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_tab[i];
            end
        end
        sn = y;
        cs = flip ? -x : x;
    endfunction

    function automatic logic [31:0] solve_eccentric(input logic signed [31:0] m_in,
                                                    input logic [31:0] e_in);
        longint m;
        longint mag_m;
        longint rem;
        longint ecc;
        longint est;
        longint sn;
        longint cs;
        longint step;
        longint num;
        longint den;
        longint delta;
        longint mag;
        longint q;
        bit fallback;
        m = longint'(m_in);
        mag_m = (m < 0) ? -m : m;
        rem = (mag_m << 28) % longint'(PERIOD_RED);
        m = (rem + (64'sd1 << 27)) >>> 28;
        if (m_in < 0)
            m = -m;
        ecc = longint'({32'd0, e_in});
        est = 0;
        for (int it = 0; it < MAX_ITERATIONS; it++)
        begin
            rotate_estimate(est, sn, cs);
            step = m + ((ecc * sn + (64'sd1 <<< (61 - ANGLE_FRAC_BITS)))
                        >>> (62 - ANGLE_FRAC_BITS));
            num = step - est;
            den = (64'sd1 <<< 32) - ((ecc * cs + (64'sd1 <<< 29)) >>> 30);
            if (den < 1)
                den = 1;
            mag = (num < 0) ? -num : num;
            delta = 0;
            if (mag >= (64'sd1 <<< 31))
                fallback = 1'b1;
            else
            begin
                q = ((mag << 32) + (den >>> 1)) / den;
                fallback = q > (64'sd1 <<< (ANGLE_FRAC_BITS + 1));
                delta = (num < 0) ? -q : q;
            end
            if (fallback)
                est = sat32(step);
            else
                est = sat32(est + delta);
            if (!fallback && delta == 0)
                break;
        end
        return est[31:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] want;
        if (!rst_n)
        begin
            anomaly_q.delete();
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                anomaly_q.push_back(solve_eccentric(mean_anomaly, eccentricity));
            if (out_valid && out_ready)
            begin
                if (anomaly_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result transfer: got %0d", eccentric_anomaly);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = anomaly_q.pop_front();
                    if (want !== eccentric_anomaly)
                    begin
                        if (fail_count < 10)
                            $display("eccentric_anomaly mismatch: expected %0d got %0d",
                                     $signed(want), eccentric_anomaly);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= anomaly_q.size();
        end
    end

endmodule

// ===== tb/kepler_eccentric_anomaly_solver_unit_tb.sv =====
module kepler_eccentric_anomaly_solver_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] mean_anomaly;
    logic        [31:0] eccentricity;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] eccentric_anomaly;
    int                 fail_count;
    int                 pending;

    // Toggled by the stimulus to ask the receiver for one long hold-off.
    bit                 hold_req;

    kepler_eccentric_anomaly_solver_unit u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .mean_anomaly      (mean_anomaly),
        .eccentricity      (eccentricity),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .eccentric_anomaly (eccentric_anomaly)
    );

    kes_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .mean_anomaly      (mean_anomaly),
        .eccentricity      (eccentricity),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .eccentric_anomaly (eccentric_anomaly),
        .fail_count        (fail_count),
        .pending           (pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Receiver: runs of random length in one of several stall modes, from
    // always ready to mostly stalled. A toggle of hold_req makes it hold
    // out_ready low for a long stretch so the solver backs up into its input.
    initial
    begin
        bit seen;
        int mode;
        int run_left;
        out_ready = 1'b0;
        seen = 1'b0;
        mode = 0;
        run_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (seen != hold_req)
            begin
                seen = hold_req;
                out_ready <= 1'b0;
                repeat (6000) @(posedge clk);
            end
            if (run_left == 0)
            begin
                mode = $urandom_range(0, 3);
                run_left = $urandom_range(5, 60);
            end
            run_left--;
            case (mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                2:       out_ready <= $urandom_range(0, 1);
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    int burst_left;

    // Offers one item and returns at the rising edge where the transfer
    // happens. Between bursts the valid line drops for a random gap; inside a
    // burst it stays high and only the payload changes.
    task automatic offer(input logic [31:0] m, input logic [31:0] e);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        in_valid     <= 1'b1;
        mean_anomaly <= m;
        eccentricity <= e;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_eccentricity();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 32'h0FFF_FFFF);
            1:       return 32'hF000_0000 | $urandom_range(0, 32'h0FFF_FFFF);
            2:       return 32'hFFFF_FF00 | $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_anomaly();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 32'h3200_0000) ^
                            ({32{$urandom_range(0, 1) == 1}});
            1:       return $urandom_range(0, 255) - 128;
            default: return $urandom;
        endcase
    endfunction

    // Q4.27 constants near the reduction and folding boundaries.
    localparam logic [31:0] TWO_PI_Q27 = 32'd843314857;
    localparam logic [31:0] PI_Q27     = 32'd421657428;

    initial
    begin
        in_valid     = 1'b0;
        mean_anomaly = '0;
        eccentricity = '0;
        rst_n        = 1'b0;
        burst_left   = 0;
        hold_req     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, exact and off-by-one multiples of 2*pi,
        // eccentricity close to one where the divisor may collapse and the
        // fixed-point fallback is taken.
        offer(32'h0000_0000, 32'h0000_0000);
        offer(32'h7FFF_FFFF, 32'h0000_0000);
        offer(32'h8000_0000, 32'h0000_0000);
        offer(32'h0000_0001, 32'hFFFF_FFFF);
        offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer(32'h0000_0000, 32'hFFFF_FFFF);
        offer(32'h7FFF_FFFF, 32'hFFFF_FFFF);
        offer(32'h8000_0000, 32'hFFFF_FFFF);
        offer(TWO_PI_Q27, 32'h8000_0000);
        offer(-TWO_PI_Q27, 32'h8000_0000);
        offer(TWO_PI_Q27 - 1, 32'hFFFF_0000);
        offer(TWO_PI_Q27 + 1, 32'hFFFF_0000);
        offer(PI_Q27, 32'hFFFF_FFFF);
        offer(-PI_Q27, 32'hFFFF_FFFF);
        offer(PI_Q27 >> 1, 32'h0000_0001);
        offer(32'h0000_0100, 32'hFFFF_FFF0);
        offer(-32'sd256, 32'hFFFF_FFF0);
        offer(32'h5555_5555, 32'hAAAA_AAAA);
        offer(32'hAAAA_AAAA, 32'h5555_5555);
        offer(32'h1000_0000, 32'h0000_0000);

        for (int n = 0; n < 350; n++)
        begin
            if (n == 100)
            begin
                in_valid <= 1'b0;
                @(negedge clk) hold_req = ~hold_req;
                @(posedge clk);
            end
            if (n == 200)
            begin
                in_valid <= 1'b0;
                do
                    @(negedge clk);
                while (pending != 0);
                @(posedge clk);
            end
            offer(pick_anomaly(), pick_eccentricity());
        end
        in_valid <= 1'b0;

        do
            @(negedge clk);
        while (pending != 0);
        repeat (2000) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("kepler_eccentric_anomaly_solver_unit_tb OK");
        else
            $display("kepler_eccentric_anomaly_solver_unit_tb NOT OK");
        $finish;
    end

    initial
    begin
        #36ms;
        $display("kepler_eccentric_anomaly_solver_unit_tb NOT OK");
        $finish;
    end

endmodule
